[design/bdcl_pkg.sv]
// Package for the button debouncer with click and long-press pulses.
// Holds the beat structs, the configuration types, register indexes and reset values.
// No dependencies.
package bdcl_pkg;

  // Width of the internal time arithmetic; differences wrap modulo 2^TimeWidth (16..64)
  localparam int unsigned TimeWidth   = 32;
  localparam int unsigned NowWidth    = 32;
  localparam int unsigned MsWidth     = 16;
  localparam int unsigned CfgIdxWidth = 4;

  typedef logic [TimeWidth-1:0]   time_t;
  typedef logic [MsWidth-1:0]     ms_t;
  typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

  // Register indexes on the configuration port
  localparam cfg_idx_t CfgIdxDebounce  = cfg_idx_t'(0);
  localparam cfg_idx_t CfgIdxLongPress = cfg_idx_t'(1);

  // Register reset values
  localparam ms_t DebounceReset  = ms_t'(50);
  localparam ms_t LongPressReset = ms_t'(1000);

  // Pin levels (active-low button)
  localparam logic LevelPressed  = 1'b0;
  localparam logic LevelReleased = 1'b1;

  // Input beat: sampled pin level and timestamp
  typedef struct packed {
    logic                level;
    logic [NowWidth-1:0] now_ms;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic click;
    logic long_press;
    logic stable_level;
  } out_beat_t;

  // Configuration register contents
  typedef struct packed {
    ms_t debounce_ms;
    ms_t long_press_ms;
  } cfg_t;

endpackage

[design/bdcl_cfg_regs.sv]
// Configuration registers of the button debouncer: debounce and long-press times.
// Depends on bdcl_pkg.
module bdcl_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  bdcl_pkg::cfg_idx_t cfg_index_i,
  input  bdcl_pkg::ms_t     cfg_data_i,
  output logic              cfg_ready_o,
  output bdcl_pkg::cfg_t    cfg_o
);
  import bdcl_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Writes are always taken; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgIdxDebounce:  cfg_d.debounce_ms   = cfg_data_i;
        CfgIdxLongPress: cfg_d.long_press_ms = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= DebounceReset;
      cfg_q.long_press_ms <= LongPressReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/bdcl_qualify.sv]
// Debounce state and per-beat qualification: stable level, click and long-press pulses.
// State advances once per beat leaving the input register. Depends on bdcl_pkg.
module bdcl_qualify (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  bdcl_pkg::in_beat_t  beat_i,
  input  bdcl_pkg::cfg_t      cfg_i,
  output bdcl_pkg::out_beat_t result_o
);
  import bdcl_pkg::*;

  logic  prev_level_q, prev_level_d;
  time_t change_time_q, change_time_d;
  logic  deb_level_q, deb_level_d;
  time_t press_time_q, press_time_d;
  logic  long_done_q, long_done_d;

  time_t now;
  time_t held;
  time_t pressed_for;
  logic  settled;
  logic  click;
  logic  long_press;

  assign now = time_t'(beat_i.now_ms);

  // Level qualification, then long-press check on the updated state
  always_comb begin
    prev_level_d  = beat_i.level;
    change_time_d = (beat_i.level != prev_level_q) ? now : change_time_q;
    held          = now - change_time_d;
    settled       = held > time_t'(cfg_i.debounce_ms);
    deb_level_d   = deb_level_q;
    press_time_d  = press_time_q;
    long_done_d   = long_done_q;
    click         = 1'b0;
    long_press    = 1'b0;
    if (settled && (beat_i.level != deb_level_q)) begin
      deb_level_d = beat_i.level;
      if (beat_i.level == LevelPressed) begin
        press_time_d = now;
        long_done_d  = 1'b0;
      end else if (!long_done_q) begin
        click = 1'b1;
      end
    end
    pressed_for = now - press_time_d;
    if (settled && (deb_level_d == LevelPressed) && !long_done_d &&
        (pressed_for >= time_t'(cfg_i.long_press_ms))) begin
      long_done_d = 1'b1;
      long_press  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q  <= LevelReleased;
      change_time_q <= '0;
      deb_level_q   <= LevelReleased;
      press_time_q  <= '0;
      long_done_q   <= 1'b0;
    end else if (step_i) begin
      prev_level_q  <= prev_level_d;
      change_time_q <= change_time_d;
      deb_level_q   <= deb_level_d;
      press_time_q  <= press_time_d;
      long_done_q   <= long_done_d;
    end
  end

  assign result_o.click        = click;
  assign result_o.long_press   = long_press;
  assign result_o.stable_level = deb_level_d;

endmodule

[design/button_debounce_click_long_press_core.sv]
// Button debouncer with click and long-press pulses for one active-low button.
// Input channel: in_valid_i / in_stall_o carry one beat per pin sample (level, now_ms).
// Result channel: out_valid_o / out_stall_i carry one beat per input beat
// (click, long_press, stable_level), in order.
// Configuration: cfg_valid_i / cfg_ready_o write debounce_ms (index 0) or
// long_press_ms (index 1); other indexes are ignored. Write only while idle.
// Path: a beat accepted into the input register is qualified into the result register
// once that register is empty or its beat is taken.
// Throughput: one beat per cycle while out_stall_i is low; the debounce state update
// is a single pass of subtract-and-compare logic between the input and result registers.
// Stall: while the result beat waits, one further input beat is held in the input
// register; in_stall_o rises only when both registers are full and out_stall_i is high.
// Reset: both channels empty, level released, times zero, no long press pending,
// debounce_ms = 50 and long_press_ms = 1000.
// Depends on bdcl_pkg, bdcl_cfg_regs and bdcl_qualify.
module button_debounce_click_long_press_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bdcl_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bdcl_pkg::out_beat_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  bdcl_pkg::cfg_idx_t  cfg_index_i,
  input  bdcl_pkg::ms_t       cfg_data_i
);
  import bdcl_pkg::*;

  cfg_t      cfg;
  in_beat_t  in_beat_q;
  logic      in_vld_q, in_vld_d;
  out_beat_t out_beat_q;
  out_beat_t result;
  logic      out_vld_q, out_vld_d;
  logic      advance;
  logic      accept_in;
  logic      step;

  bdcl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  // Handshake: result register frees when empty or taken
  assign advance    = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !advance;
  assign accept_in  = in_valid_i && !in_stall_o;
  assign step       = in_vld_q && advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept_in) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = advance ? in_vld_q : out_vld_q;
  end

  bdcl_qualify u_qualify (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .beat_i   (in_beat_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      in_beat_q <= in_data_i;
    end
    if (step) begin
      out_beat_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_beat_q;

endmodule

[design/bdcl_checker.sv]
// Port-level checker for the button debouncer, bound to the top level.
// Depends on bdcl_pkg and button_debounce_click_long_press_core.
module bdcl_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input bdcl_pkg::out_beat_t out_data_o
);
  import bdcl_pkg::*;

  // A click comes on release, a long press while pressed: never both
  a_pulse_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.click && out_data_o.long_press))
    else $error("click and long_press in one beat");

  // Pulses agree with the debounced level they report
  a_pulse_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((!out_data_o.click || out_data_o.stable_level == LevelReleased) &&
                     (!out_data_o.long_press || out_data_o.stable_level == LevelPressed)))
    else $error("pulse inconsistent with stable_level");

  // The input side stalls only behind a waiting result beat
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with result side free");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result beat changed");

endmodule

bind button_debounce_click_long_press_core bdcl_checker u_bdcl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[bench/bdcl_result_checker.sv]
// Result checker for the button debouncer core: watches the sample, result and
// configuration channels, predicts each result beat and compares them in order.
// Depends on bdcl_pkg.
module bdcl_result_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  bdcl_pkg::in_beat_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  bdcl_pkg::out_beat_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  bdcl_pkg::cfg_idx_t  cfg_index_i,
  input  bdcl_pkg::ms_t       cfg_data_i,
  output logic [31:0]         fail_count_o,
  output logic [31:0]         pending_o,
  output logic [31:0]         results_o,
  output logic [31:0]         clicks_o,
  output logic [31:0]         long_presses_o
);
  import bdcl_pkg::*;

  localparam int unsigned MaxPrinted = 20;

  // Register copies, as last written on the configuration port
  ms_t   debounce_cfg;
  ms_t   long_press_cfg;

  // Debounce state
  logic  last_raw;
  logic  debounced;
  logic  long_fired;
  time_t raw_change_ms;
  time_t press_ms;

  out_beat_t   expected_q[$];
  int unsigned mismatches   = 0;
  int unsigned pending      = 0;
  int unsigned results      = 0;
  int unsigned clicks       = 0;
  int unsigned long_presses = 0;

  assign fail_count_o   = mismatches;
  assign pending_o      = pending;
  assign results_o      = results;
  assign clicks_o       = clicks;
  assign long_presses_o = long_presses;

  // One line per mismatch, printing capped so a broken block cannot flood the log
  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("[%0t] result beat %0d: %s", $time, results, what);
    end
  endtask

  // Advance the debounce state by one pin sample and return the expected beat
  function automatic out_beat_t qualify_sample(in_beat_t sample);
    out_beat_t r;
    time_t     now;
    time_t     steady;
    time_t     held;
    r   = '0;
    now = time_t'(sample.now_ms);
    if (sample.level != last_raw) begin
      raw_change_ms = now;
    end
    steady = now - raw_change_ms;
    if (steady > debounce_cfg) begin
      if (sample.level != debounced) begin
        debounced = sample.level;
        if (debounced == LevelPressed) begin
          press_ms   = now;
          long_fired = 1'b0;
        end else if (!long_fired) begin
          r.click = 1'b1;
        end
      end
      // long-press check sees the level accepted on this same sample
      held = now - press_ms;
      if (debounced == LevelPressed && !long_fired && held >= long_press_cfg) begin
        long_fired   = 1'b1;
        r.long_press = 1'b1;
      end
    end
    last_raw       = sample.level;
    r.stable_level = debounced;
    return r;
  endfunction

  // Compare one result beat with the oldest expectation, field by field
  task automatic compare_result(out_beat_t got);
    out_beat_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result beat with nothing pending");
    end else begin
      want = expected_q.pop_front();
      if (got.click !== want.click) begin
        report_mismatch($sformatf("click %b, want %b", got.click, want.click));
      end
      if (got.long_press !== want.long_press) begin
        report_mismatch($sformatf("long_press %b, want %b", got.long_press, want.long_press));
      end
      if (got.stable_level !== want.stable_level) begin
        report_mismatch($sformatf("stable_level %b, want %b",
                                  got.stable_level, want.stable_level));
      end
    end
    if (got.click === 1'b1) clicks++;
    if (got.long_press === 1'b1) long_presses++;
    results++;
  endtask

  // Results are retired before new samples are queued: a sample cannot produce
  // its result on the edge that accepts it
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_cfg   = DebounceReset;
      long_press_cfg = LongPressReset;
      last_raw       = LevelReleased;
      debounced      = LevelReleased;
      long_fired     = 1'b0;
      raw_change_ms  = '0;
      press_ms       = '0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgIdxDebounce:  debounce_cfg   = cfg_data_i;
          CfgIdxLongPress: long_press_cfg = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        compare_result(out_data_i);
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(qualify_sample(in_data_i));
      end
    end
    pending = expected_q.size();
  end

endmodule

[bench/button_debounce_click_long_press_core_tb.sv]
// Testbench top for the button debouncer core: drives pin-sample and register
// beats, random stalls and long output hold-offs, and gives the verdict.
// Depends on bdcl_pkg, the core and bdcl_result_checker.
module button_debounce_click_long_press_core_tb;
  import bdcl_pkg::*;

  localparam int unsigned HoldOffCycles = 40;
  localparam int unsigned PhaseBeats    = 95;
  localparam int unsigned TimeoutUnits  = 400000;
  localparam ms_t         MsMax         = '1;
  localparam cfg_idx_t    CfgIdxSpare   = CfgIdxLongPress + cfg_idx_t'(1);
  localparam cfg_idx_t    CfgIdxTop     = '1;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_beat_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index = '0;
  ms_t       cfg_data  = '0;

  logic [31:0] fail_count;
  logic [31:0] pending;
  logic [31:0] results;
  logic [31:0] clicks;
  logic [31:0] long_presses;

  // Stimulus state
  logic [31:0] clock_ms       = '0;
  int unsigned cur_debounce   = 32'(DebounceReset);
  int unsigned cur_long       = 32'(LongPressReset);
  bit          tx_idle_on     = 1'b1;
  bit          rx_idle_on     = 1'b1;
  bit          hold_req       = 1'b0;
  int unsigned beats_sent     = 0;
  int unsigned cfg_writes     = 0;
  int unsigned holdoffs       = 0;
  int unsigned stalled_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  button_debounce_click_long_press_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  bdcl_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_data_i     (out_data),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results),
    .clicks_o       (clicks),
    .long_presses_o (long_presses)
  );

  // Input back-pressure seen while offering a beat
  always @(posedge clk_i) begin
    if (in_valid && in_stall) stalled_cycles++;
  end

  // Result receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        holdoffs++;
        hold_req = 1'b0;
      end
      out_stall <= rx_idle_on && ($urandom_range(0, 99) < 20);
    end
  end

  // Offer one sample beat and wait until it is taken; valid stays high afterwards
  task automatic send_beat(logic lvl);
    in_beat_t beat;
    beat.level  = lvl;
    beat.now_ms = clock_ms;
    if (tx_idle_on && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk_i); while (in_stall);
    beats_sent++;
  endtask

  task automatic emit(logic lvl, int unsigned step);
    clock_ms += step;
    send_beat(lvl);
  endtask

  task automatic sample_at(logic lvl, logic [31:0] at_ms);
    clock_ms = at_ms;
    send_beat(lvl);
  endtask

  // Drop valid and wait for every expected result, with added slack
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, ms_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      CfgIdxDebounce:  cur_debounce = 32'(value);
      CfgIdxLongPress: cur_long     = 32'(value);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Contact bounce ending on the target level
  task automatic bounce(logic target);
    int unsigned jitter;
    jitter = cur_debounce / 4 + 2;
    repeat ($urandom_range(0, 3)) emit($urandom_range(0, 1) == 1, $urandom_range(0, jitter));
    emit(target, $urandom_range(0, jitter));
  endtask

  // Hold a level for dur ms, spread over one to four samples
  task automatic hold_level(logic lvl, int unsigned dur);
    int unsigned parts;
    int unsigned slice;
    parts = $urandom_range(1, 4);
    slice = dur / parts;
    repeat (parts - 1) emit(lvl, slice);
    emit(lvl, dur - slice * (parts - 1));
  endtask

  // One press and release with bounce; the hold time picks glitch, click or long press
  task automatic press_cycle();
    int unsigned dur;
    bounce(LevelPressed);
    case ($urandom_range(0, 4))
      0:       dur = $urandom_range(0, cur_debounce);
      1:       dur = cur_debounce + 1;
      2:       dur = cur_debounce + 1 + $urandom_range(0, cur_long);
      3:       dur = cur_debounce + 1 + cur_long;
      default: dur = cur_debounce + cur_long + 1 + $urandom_range(0, cur_long + 50);
    endcase
    hold_level(LevelPressed, dur);
    bounce(LevelReleased);
    hold_level(LevelReleased, cur_debounce + 1 + $urandom_range(0, cur_debounce / 2 + 20));
  endtask

  // Stray samples: random level, either a small step or a jump anywhere in time
  task automatic noise_sample();
    if ($urandom_range(0, 3) == 0) begin
      clock_ms = $urandom;
      emit($urandom_range(0, 1) == 1, 0);
    end else begin
      emit($urandom_range(0, 1) == 1, $urandom_range(0, 3));
    end
  endtask

  task automatic run_phase(int unsigned count, bit hold);
    int unsigned stop_at;
    int unsigned hold_at;
    stop_at = beats_sent + count;
    hold_at = beats_sent + count / 3;
    while (beats_sent < stop_at) begin
      if (hold && beats_sent >= hold_at) begin
        hold_req = 1'b1;
        hold     = 1'b0;
      end
      if ($urandom_range(0, 99) < 15) begin
        noise_sample();
      end else begin
        press_cycle();
      end
    end
    drain();
  endtask

  // Hand-picked samples: thresholds, wrap, zero times, ignored registers
  task automatic directed_sequence();
    // reset values: 50 ms debounce, 1000 ms long press
    sample_at(LevelReleased, 32'h0000_0000);
    sample_at(LevelPressed,  32'd10);
    sample_at(LevelPressed,  32'd60);          // held exactly 50: not yet
    sample_at(LevelPressed,  32'd61);          // accepted, press time 61
    sample_at(LevelPressed,  32'd1060);        // held 999
    sample_at(LevelPressed,  32'd1061);        // held 1000: long press
    sample_at(LevelReleased, 32'd1500);
    sample_at(LevelReleased, 32'd1551);        // release after long press: no click
    sample_at(LevelPressed,  32'd2000);
    sample_at(LevelPressed,  32'd2051);
    sample_at(LevelReleased, 32'd2100);
    sample_at(LevelReleased, 32'd2151);        // click
    // press across the wrap of the millisecond counter
    sample_at(LevelPressed,  32'hFFFF_FFE0);
    sample_at(LevelPressed,  32'h0000_0013);
    sample_at(LevelReleased, 32'h0000_0100);
    sample_at(LevelReleased, 32'h0000_0133);
    sample_at(LevelPressed,  32'hFFFF_FFFF);
    sample_at(LevelReleased, 32'hFFFF_FFFF);
    drain();
    // zero debounce and zero long-press time; spare indexes must be ignored
    write_reg(CfgIdxDebounce, '0);
    write_reg(CfgIdxLongPress, '0);
    write_reg(CfgIdxSpare, MsMax);
    write_reg(CfgIdxTop, MsMax);
    sample_at(LevelPressed,  32'd5000);
    sample_at(LevelPressed,  32'd5001);        // press and long press together
    sample_at(LevelReleased, 32'd5002);
    sample_at(LevelReleased, 32'd5003);        // no click
    drain();
    write_reg(CfgIdxLongPress, MsMax);
    sample_at(LevelPressed,  32'd6000);
    sample_at(LevelPressed,  32'd6001);
    sample_at(LevelReleased, 32'd6002);
    sample_at(LevelReleased, 32'd6003);        // release and click on one sample
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_sequence();

    // reset values again, both sides idling
    write_reg(CfgIdxDebounce, DebounceReset);
    write_reg(CfgIdxLongPress, LongPressReset);
    clock_ms = $urandom;
    run_phase(PhaseBeats, 1'b0);

    // zero times, with the output held off long enough to back up the input
    write_reg(CfgIdxDebounce, '0);
    write_reg(CfgIdxLongPress, '0);
    run_phase(PhaseBeats, 1'b1);

    // largest times, no idling on either side, counter wraps during the phase
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_reg(CfgIdxDebounce, MsMax);
    write_reg(CfgIdxLongPress, MsMax);
    clock_ms = 32'hFFFF_0000;
    run_phase(PhaseBeats, 1'b0);

    // moderate random times, idling back on, second hold-off
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    write_reg(CfgIdxDebounce, ms_t'($urandom_range(0, 300)));
    write_reg(CfgIdxLongPress, ms_t'($urandom_range(0, 3000)));
    clock_ms = $urandom;
    run_phase(PhaseBeats, 1'b1);

    // minimal non-zero times
    write_reg(CfgIdxDebounce, ms_t'(1));
    write_reg(CfgIdxLongPress, ms_t'(1));
    write_reg(CfgIdxSpare, '0);
    run_phase(PhaseBeats, 1'b0);

    repeat (8) @(posedge clk_i);
    $display("covered %0d pin samples and %0d register writes; %0d results, %0d clicks, %0d long presses",
             beats_sent, cfg_writes, results, clicks, long_presses);
    $display("input held back for %0d cycles over %0d long output hold-offs",
             stalled_cycles, holdoffs);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TimeoutUnits);
    $display("timeout with %0d results still pending", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[button_debounce_click_long_press_core.f]
design/bdcl_pkg.sv
design/bdcl_cfg_regs.sv
design/bdcl_qualify.sv
design/button_debounce_click_long_press_core.sv
design/bdcl_checker.sv
bench/bdcl_result_checker.sv
bench/button_debounce_click_long_press_core_tb.sv
